[src/int32_to_decimal_ascii_assert.svh]
// assertion macros shared by the converter modules
// each expects i_clk and i_rst_n in the scope where it is used
`ifndef INT32_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2D_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/i2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types, constants and power-of-ten table for the decimal converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

    localparam int NUM_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 4;
    localparam int WIDE_W      = NUM_W + 2;
    localparam int MAX_POS     = 9;
    localparam int DIGIT_BASE  = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // one number waiting for the digit generator
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [POS_W-1:0] pos;
    } t_job;

    // 10 ** pos, wide enough that nine times the largest still fits
    function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [WIDE_W-1:0] p;
        unique case (pos)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

[src/i2d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_front
// Input stage: takes a number, splits off the sign, takes the magnitude and
// counts its decimal digits before handing the job to the queue.
// ----------------------------------------------------------------------------
module i2d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [i2d_pkg::NUM_W-1:0]     i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_q_full,
    output logic                          o_push,
    output i2d_pkg::t_job                 o_job
);

    logic                          r_valid;
    logic                          r_neg;
    logic [i2d_pkg::NUM_W-1:0]     r_mag;
    logic                          w_accept;
    logic                          w_neg;
    logic [i2d_pkg::POS_W-1:0]     w_pos;
    logic [i2d_pkg::WIDE_W-1:0]    w_mag_wide;

    // stage frees up whenever its job moves into the queue
    assign o_push     = r_valid & ~i_q_full;
    assign o_s_tready = ~r_valid | ~i_q_full;
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_neg      = i_s_tuser & i_s_tdata[i2d_pkg::NUM_W-1];

    // stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // sign and magnitude, most negative value wraps to 2**31
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_neg;
            r_mag <= w_neg ? (i2d_pkg::NUM_W'(0) - i_s_tdata) : i_s_tdata;
        end
    end

    // index of the leading digit: how many powers of ten the value reaches
    assign w_mag_wide = {2'b00, r_mag};
    always_comb begin
        w_pos = '0;
        for (int k = 1; k <= i2d_pkg::MAX_POS; k++) begin
            if (w_mag_wide >= i2d_pkg::pow10(i2d_pkg::POS_W'(k))) begin
                w_pos = w_pos + 1'b1;
            end
        end
    end

    assign o_job = '{neg: r_neg, mag: r_mag, pos: w_pos};

endmodule

[src/i2d_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_queue
// Small register FIFO between the input stage and the digit generator.
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_assert.svh"

module i2d_queue #(
    parameter int DEPTH = i2d_pkg::QUEUE_DEPTH,
    parameter int WIDTH = $bits(i2d_pkg::t_job)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // pointer wrap for any depth
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    `I2D_ASSERT_IMPL(a_no_overflow, i_push, !o_full, "push into a full queue")
    `I2D_ASSERT_IMPL(a_no_underflow, i_pop, o_valid, "pop from an empty queue")
    `I2D_ASSERT_NEXT(a_count_step, i_push && !i_pop, r_count == $past(r_count) + 1'b1,
                     "fill count did not follow a push")

endmodule

[src/i2d_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_back
// Digit generator: emits the sign, then one decimal digit per cycle while the
// output is free, most significant first, against multiples of 10 ** pos.
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_assert.svh"

module i2d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  i2d_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [i2d_pkg::CHAR_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int NDIG = i2d_pkg::DIGIT_BASE;

    logic                          r_active;
    logic                          r_neg;
    logic [i2d_pkg::NUM_W-1:0]     r_mag;
    logic [i2d_pkg::POS_W-1:0]     r_pos;
    logic                          r_out_valid;
    logic [i2d_pkg::CHAR_W-1:0]    r_out_char;
    logic                          r_out_last;

    logic                          w_adv;
    logic                          w_emit;
    logic                          w_fin;
    logic [i2d_pkg::WIDE_W-1:0]    w_p10;
    logic [i2d_pkg::WIDE_W-1:0]    w_limit;
    logic [i2d_pkg::WIDE_W-1:0]    w_mag_wide;
    logic [i2d_pkg::WIDE_W-1:0]    w_thr [NDIG];
    logic [i2d_pkg::POS_W-1:0]     w_digit;
    logic [i2d_pkg::NUM_W-1:0]     w_rem;
    logic [i2d_pkg::CHAR_W-1:0]    w_char;
    logic                          w_last;
    logic                          w_mag_ok;

    // output register frees when empty or taken
    assign w_adv  = ~r_out_valid | i_m_tready;
    assign w_emit = r_active & w_adv;
    assign w_fin  = w_emit & ~r_neg & (r_pos == '0);
    assign o_pop  = i_q_valid & (~r_active | w_fin);

    // multiples of the current power of ten
    assign w_p10      = i2d_pkg::pow10(r_pos);
    assign w_limit    = w_p10 * i2d_pkg::WIDE_W'(NDIG);
    assign w_mag_wide = {2'b00, r_mag};
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_thr[d] = w_p10 * i2d_pkg::WIDE_W'(d);
        end
    end

    // largest digit whose multiple still fits, and what is left over
    always_comb begin
        w_digit = '0;
        for (int d = 1; d < NDIG; d++) begin
            if (w_mag_wide >= w_thr[d]) begin
                w_digit = i2d_pkg::POS_W'(d);
            end
        end
        w_rem = r_mag - w_thr[w_digit][i2d_pkg::NUM_W-1:0];
    end

    // character for this step
    always_comb begin
        if (r_neg) begin
            w_char = i2d_pkg::ASCII_MINUS;
            w_last = 1'b0;
        end else begin
            w_char = i2d_pkg::ASCII_ZERO + i2d_pkg::CHAR_W'(w_digit);
            w_last = (r_pos == '0);
        end
    end

    // job control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop) begin
            r_active <= 1'b1;
        end else if (w_fin) begin
            r_active <= 1'b0;
        end
    end

    // working value: sign first, then one digit per step
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg <= i_job.neg;
            r_mag <= i_job.mag;
            r_pos <= i_job.pos;
        end else if (w_emit) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_mag <= w_rem;
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

    assign w_mag_ok = (w_mag_wide < w_limit);

    `I2D_ASSERT_IMPL(a_mag_in_range, r_active, w_mag_ok && (r_pos <= 4'd9),
                     "remaining value has more digits than the position allows")
    `I2D_ASSERT_NEXT(a_fin_flags_last, w_fin, o_m_tvalid && o_m_tlast,
                     "final digit did not leave with the last flag")
    `I2D_ASSERT_IMPL(a_pop_only_free, o_pop, !r_active || w_fin,
                     "new job loaded over a job still in progress")

endmodule

[src/int32_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// 32-bit binary to decimal ASCII text, unsigned or two's-complement signed.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transfer per number; tdata carries the 32-bit value,
//   tuser bit 0 selects signed reading (1) or unsigned reading (0).
//   Master channel: one transfer per character, most significant digit
//   first, led by '-' for a negative signed value; tlast marks the final
//   digit. Zero gives a single '0'; no leading zeros are sent.
//   Path: a number passes the input stage register, the queue entry, the
//   digit generator's working registers and the output register.
//   Throughput: one character per cycle while the receiver takes them; a
//   number has 1 to 11 characters. The digit generator, which settles one
//   digit per cycle against the multiples of a power of ten, sets this rate.
//   The input stage and a two-entry queue keep taking numbers while the
//   digit generator works, so input stalls only when both are full.
//   A stalled receiver holds the output register; digit generation pauses
//   and resumes without loss.
//   Reset (synchronous, active low) empties the input stage, the queue and
//   the output register; any partly sent number is dropped.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = i2d_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [i2d_pkg::NUM_W-1:0]     i_s_tdata,   // [31:0] number
    input  logic                          i_s_tuser,   // [0] mode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [i2d_pkg::CHAR_W-1:0]    o_m_tdata,   // [7:0] char_out
    output logic                          o_m_tlast
);

    logic          w_push;
    logic          w_pop;
    logic          w_q_full;
    logic          w_q_valid;
    i2d_pkg::t_job w_job_in;
    i2d_pkg::t_job w_job_out;

    // sign split and digit count
    i2d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    // jobs waiting for the digit generator
    i2d_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(i2d_pkg::t_job))
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_job_in),
        .i_pop     (w_pop),
        .o_full    (w_q_full),
        .o_valid   (w_q_valid),
        .o_rd_data (w_job_out)
    );

    // character generation
    i2d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[sim/int32_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_tb
// Self-checking bench for the 32-bit binary to decimal ASCII converter.
// Numbers go in on the slave stream in both readings. Each accepted number is
// expanded here into the characters it should print, and every character
// leaving the master stream is checked against the oldest one still owed.
// Both sides idle at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_tb;

    localparam logic [i2d_pkg::NUM_W-1:0] TEN        = 32'd10;
    localparam logic                      MODE_UNS   = 1'b0;
    localparam logic                      MODE_SGN   = 1'b1;
    localparam int                        MAX_IDLE   = 19;
    localparam int                        RANDOM_CNT = 210;

    // one number waiting to be sent, with the idle time that follows it
    typedef struct {
        logic [i2d_pkg::NUM_W-1:0] number;
        logic                      mode;
        int                        gap;
        bit                        drain;
    } t_number_item;

    // one character owed by the converter
    typedef struct {
        logic [i2d_pkg::CHAR_W-1:0] ch;
        logic                       is_last;
    } t_owed_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [i2d_pkg::NUM_W-1:0] i_s_tdata = '0;   // [31:0] number
    logic i_s_tuser = 1'b0;                      // [0] mode
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [i2d_pkg::CHAR_W-1:0] o_m_tdata;       // [7:0] char_out
    logic o_m_tlast;

    t_number_item numbers_to_send[$];
    t_owed_char   owed_chars[$];

    bit   num_taken = 1'b0;
    bit   char_taken = 1'b0;
    int   send_wait = 0;
    bit   send_drain = 1'b0;
    int   rx_stall = 0;
    int   rx_count = 0;
    bit   rx_quiet = 1'b0;
    bit   tx_quiet = 1'b0;
    int   error_count = 0;

    int32_to_decimal_ascii u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void owe_char(input logic [i2d_pkg::CHAR_W-1:0] ch,
                                     input logic is_last);
        t_owed_char c;
        c.ch = ch;
        c.is_last = is_last;
        owed_chars.push_back(c);
    endfunction

    // decimal text of one number: optional sign, then digits msd first
    function automatic void owe_decimal_text(input logic [i2d_pkg::NUM_W-1:0] number,
                                             input logic mode);
        logic [i2d_pkg::NUM_W-1:0]  mag;
        logic [i2d_pkg::CHAR_W-1:0] digits [0:9];
        int                         ndig;
        int                         k;
        mag = number;
        ndig = 0;
        if (mode == MODE_SGN && number[i2d_pkg::NUM_W-1]) begin
            owe_char(i2d_pkg::ASCII_MINUS, 1'b0);
            mag = -number;
        end
        do begin
            digits[ndig] = i2d_pkg::ASCII_ZERO + i2d_pkg::CHAR_W'(mag % TEN);
            mag = mag / TEN;
            ndig++;
        end while (mag != '0);
        for (k = ndig - 1; k >= 0; k--)
            owe_char(digits[k], k == 0);
    endfunction

    function automatic void add_number(input logic [i2d_pkg::NUM_W-1:0] number,
                                       input logic mode, input bit drain);
        t_number_item it;
        it.number = number;
        it.mode = mode;
        it.gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        it.drain = drain;
        numbers_to_send.push_back(it);
    endfunction

    // sample both handshakes; predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_owed_char e;
        num_taken <= i_s_tvalid && o_s_tready;
        char_taken <= o_m_tvalid && i_m_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (owed_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                         $time, o_m_tdata, o_m_tlast);
                error_count++;
            end else begin
                e = owed_chars.pop_front();
                if (o_m_tdata !== e.ch) begin
                    $display("%0t: char mismatch: expected 0x%02h, actual 0x%02h",
                             $time, e.ch, o_m_tdata);
                    error_count++;
                end
                if (o_m_tlast !== e.is_last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, e.is_last, o_m_tlast);
                    error_count++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            owe_decimal_text(i_s_tdata, i_s_tuser);
    end

    // sender: holds each number until its transfer, then idles as drawn
    always @(negedge i_clk) begin
        t_number_item it;
        if (i_rst_n && !(i_s_tvalid && !num_taken)) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                i_s_tvalid <= 1'b0;
            end else if (send_drain && owed_chars.size() != 0) begin
                i_s_tvalid <= 1'b0;
            end else if (numbers_to_send.size() != 0) begin
                it = numbers_to_send.pop_front();
                i_s_tdata <= it.number;
                i_s_tuser <= it.mode;
                i_s_tvalid <= 1'b1;
                send_wait <= it.gap;
                send_drain <= it.drain;
            end else begin
                i_s_tvalid <= 1'b0;
                send_drain <= 1'b0;
            end
        end
    end

    // receiver: stall drawn after each character transfer
    always @(negedge i_clk) begin
        int stall;
        if (i_rst_n) begin
            stall = rx_stall;
            if (char_taken) begin
                rx_count <= rx_count + 1;
                if (rx_count % 40 == 39)
                    rx_quiet <= ($urandom_range(0, 2) == 0);
                stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                rx_stall <= stall - 1;
                i_m_tready <= 1'b0;
            end else begin
                rx_stall <= 0;
                i_m_tready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [i2d_pkg::NUM_W-1:0] n;
        int                        i;
        // directed: zero, extremes, digit-count boundaries, sign cases
        add_number(32'd0, MODE_UNS, 1'b0);
        add_number(32'd0, MODE_SGN, 1'b0);
        add_number(32'hFFFF_FFFF, MODE_UNS, 1'b0);
        add_number(32'hFFFF_FFFF, MODE_SGN, 1'b0);
        add_number(32'h8000_0000, MODE_SGN, 1'b0);
        add_number(32'h8000_0000, MODE_UNS, 1'b0);
        add_number(32'h7FFF_FFFF, MODE_SGN, 1'b0);
        add_number(32'h7FFF_FFFF, MODE_UNS, 1'b0);
        add_number(32'd1, MODE_SGN, 1'b0);
        add_number(32'd9, MODE_UNS, 1'b0);
        add_number(32'd10, MODE_SGN, 1'b0);
        add_number(32'd99, MODE_UNS, 1'b0);
        add_number(32'd100, MODE_UNS, 1'b1);
        add_number(32'd999_999_999, MODE_UNS, 1'b0);
        add_number(32'd1_000_000_000, MODE_SGN, 1'b0);
        add_number(32'hFFFF_FFF6, MODE_SGN, 1'b0);
        add_number(32'h8000_0001, MODE_SGN, 1'b0);
        add_number(32'hAAAA_AAAA, MODE_UNS, 1'b0);
        add_number(32'h5555_5555, MODE_SGN, 1'b0);
        add_number(32'hAAAA_AAAA, MODE_SGN, 1'b0);
        // random: spread over all digit counts, signs and readings
        for (i = 0; i < RANDOM_CNT; i++) begin
            if (i % 30 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 5))
                0:       n = $urandom_range(0, 9);
                1:       n = -($urandom >> $urandom_range(0, 31));
                2:       n = $urandom;
                default: n = $urandom >> $urandom_range(0, 31);
            endcase
            add_number(n, 1'($urandom_range(0, 1)), (i % 70 == 35));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (numbers_to_send.size() != 0 || i_s_tvalid || owed_chars.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
